// ===== src/mxrs_pkg.sv =====
`default_nettype none

package mxrs_pkg;

   // request opcodes
   localparam logic [3:0] OP_RAW64   = 4'd0;
   localparam logic [3:0] OP_LOW32   = 4'd1;
   localparam logic [3:0] OP_LOW16   = 4'd2;
   localparam logic [3:0] OP_LOW8    = 4'd3;
   localparam logic [3:0] OP_BYTEWIN = 4'd4;
   localparam logic [3:0] OP_BIT     = 4'd5;
   localparam logic [3:0] OP_MODULO  = 4'd6;
   localparam logic [3:0] OP_RANGE   = 4'd7;
   localparam logic [3:0] OP_RELOAD  = 4'd8;

   // generator constants
   localparam logic [63:0] MUL_K = 64'd5443;
   localparam logic [63:0] ADD_K = 64'd1548586312338621;
   localparam int SHR_A = 19;
   localparam int SHL_B = 31;
   localparam int SHR_C = 23;
   localparam int SHL_D = 7;
   localparam logic [5:0] WIN_BASE = 6'd16;

   // divider geometry
   localparam int DVD_W = 64;
   localparam int DVS_W = 33;
   localparam logic [5:0] DIV_LAST = 6'd63;

   typedef struct packed {
      logic load_req;
      logic mul;
      logic mix;
      logic div_start;
      logic div_step;
      logic reload;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic need_draw;
      logic need_div;
      logic reload_op;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

// ===== src/mxrs_ctrl.sv =====
`default_nettype none

module mxrs_ctrl
   import mxrs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_MIX    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.need_draw) begin
               cmd.mul  = 1'b1;
               state_in = S_MIX;
            end else begin
               cmd.reload = status.reload_op;
               state_in   = S_DONE;
            end
         end
         S_MIX: begin
            cmd.mix = 1'b1;
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)     rsp_valid_in = 1'b1;
      else if (rsp_ready)   rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/mxrs_dp.sv =====
`default_nettype none

module mxrs_dp
   import mxrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic        csr_write,
   input  wire logic [63:0] csr_start_seed,
   input  wire logic [3:0]  req_opcode,
   input  wire logic [30:0] req_modulus,
   input  wire logic [31:0] req_range_low,
   input  wire logic [31:0] req_range_high,
   output logic [63:0]      rsp_random_value,
   output logic             rsp_bad_request
);

   // architectural state
   logic [63:0] seed_ff, seed_in;
   logic [63:0] gen_ff, gen_in;

   // latched request
   logic [3:0]         op_ff;
   logic [30:0]        mod_ff;
   logic signed [31:0] lo_ff;
   logic signed [31:0] hi_ff;

   // draw pipeline
   logic [63:0] product_ff;
   logic [63:0] value_ff;
   logic [63:0] mixed;

   // restoring divider
   logic [DVD_W-1:0] dvd_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [5:0]       cnt_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic [DVS_W-1:0] span;

   // output register
   logic [63:0] value_out_ff, value_out_in;
   logic        bad_out_ff, bad_out_in;

   logic        range_ok;
   logic        mod_ok;
   logic [5:0]  win_shift;
   logic [63:0] win_val;

   assign range_ok = !(lo_ff > hi_ff);
   assign mod_ok   = (mod_ff != 31'd0);

   always_comb begin
      status.reload_op = (op_ff == OP_RELOAD);
      status.need_div  = ((op_ff == OP_MODULO) && mod_ok) || ((op_ff == OP_RANGE) && range_ok);
      status.need_draw = (op_ff <= OP_BIT) || status.need_div;
      status.div_last  = (cnt_ff == DIV_LAST);
   end

   // add and xorshift mix on the registered product
   always_comb begin
      logic [63:0] t;
      t     = product_ff + ADD_K;
      t     = t ^ (t >> SHR_A);
      t     = t ^ (t << SHL_B);
      t     = t ^ (t >> SHR_C);
      t     = t ^ (t << SHL_D);
      mixed = t;
   end

   assign span = DVS_W'({hi_ff[31], hi_ff} - {lo_ff[31], lo_ff}) + DVS_W'(1);

   assign trial     = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_comb begin
      seed_in = seed_ff;
      gen_in  = gen_ff;
      if (csr_write) begin
         seed_in = csr_start_seed;
         gen_in  = csr_start_seed;
      end else if (cmd.reload) begin
         gen_in = seed_ff;
      end else if (cmd.mix) begin
         gen_in = mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         gen_ff  <= '0;
      end else begin
         seed_ff <= seed_in;
         gen_ff  <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_opcode;
         mod_ff <= req_modulus;
         lo_ff  <= req_range_low;
         hi_ff  <= req_range_high;
      end
      if (cmd.mul) product_ff <= gen_ff * MUL_K;
      if (cmd.mix) value_ff <= mixed;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= mixed;
         rem_ff <= '0;
         cnt_ff <= '0;
         if (op_ff == OP_MODULO) dvs_ff <= {2'b00, mod_ff};
         else                    dvs_ff <= span;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + 6'd1;
         if (!trial_sub[DVS_W]) rem_ff <= trial_sub[DVS_W-1:0];
         else                   rem_ff <= trial[DVS_W-1:0];
      end
   end

   // byte window: shift by bits 12..8 plus sixteen
   assign win_shift = {1'b0, value_ff[12:8]} + WIN_BASE;
   assign win_val   = value_ff >> win_shift;

   always_comb begin
      value_out_in = '0;
      bad_out_in   = 1'b0;
      case (op_ff)
         OP_RAW64:   value_out_in = value_ff;
         OP_LOW32:   value_out_in = {32'd0, value_ff[31:0]};
         OP_LOW16:   value_out_in = {48'd0, value_ff[15:0]};
         OP_LOW8:    value_out_in = {56'd0, value_ff[7:0]};
         OP_BYTEWIN: value_out_in = {56'd0, win_val[7:0]};
         OP_BIT:     value_out_in = {63'd0, value_ff[0]};
         OP_MODULO: begin
            bad_out_in = !mod_ok;
            if (mod_ok) value_out_in = {31'd0, rem_ff};
         end
         OP_RANGE: begin
            bad_out_in = !range_ok;
            if (range_ok) value_out_in = {32'd0, rem_ff[31:0] + lo_ff};
         end
         default: value_out_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         value_out_ff <= value_out_in;
         bad_out_ff   <= bad_out_in;
      end
   end

   assign rsp_random_value = value_out_ff;
   assign rsp_bad_request  = bad_out_ff;

endmodule

`default_nettype wire

// ===== src/mixed_xorshift_random_source.sv =====
`default_nettype none

// Channel  Ports                                        Direction  Notes
// req      req_valid/ready, opcode, modulus, range_*    in         one draw request
// rsp      rsp_valid/ready, random_value, bad_request   out        one result per request
// csr      csr_valid/ready, csr_start_seed              in         seed write, loads state
//
// Flow: raw/low/window/bit requests pass decode, multiply and mix before their
//   result; modulo and range then run the radix-2 restoring divider (64 steps).
//   Reload, rejected and unused opcodes go from decode straight to the result.
// Reset: synchronous; clears seed and generator state to zero.
// Stalls: a result waits in the output register while the next request is taken;
//   it is replaced only once the pending transaction has been taken.

module mixed_xorshift_random_source
   import mxrs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_opcode,
   input  wire logic [30:0] req_modulus,
   input  wire logic [31:0] req_range_low,
   input  wire logic [31:0] req_range_high,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_random_value,
   output logic             rsp_bad_request,
   // seed register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [63:0] csr_start_seed
);

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // seed writes are always taken and load the seed and generator registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sequencer: accept, decode, multiply, mix, divide, deliver
   mxrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // state, multiplier, xorshift mix, divider, result shaping
   mxrs_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_write),
      .csr_start_seed   (csr_start_seed),
      .req_opcode       (req_opcode),
      .req_modulus      (req_modulus),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_random_value (rsp_random_value),
      .rsp_bad_request  (rsp_bad_request)
   );

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a rejected request never carries a value
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_request) |-> (rsp_random_value == 64'd0))
      else $error("rejected transaction with nonzero value");

   // a new response only follows a load of the output register
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("response raised without output load");

   // divider only runs on requests that need it
   a_div_gated: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (status.need_div && !req_ready))
      else $error("divider started outside a modulo or range request");

endmodule

`default_nettype wire

// ===== tb/tb_mixed_xorshift_random_source.sv =====
`timescale 1ns / 100ps

module tb_mixed_xorshift_random_source
   import mxrs_pkg::*;
();

   // opcodes 9..15 are not decoded by the block; it answers them with a zero result
   localparam logic [3:0] OP_UNUSED_LO = 4'd9;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;

   // Slowest legal run: ~1400 transactions, each taking the full divider run plus
   // the longest sender gap and the longest receiver stall.
   localparam int CYCLE_LIMIT = 900_000;
   localparam int TAIL_CYCLES = 80;

   typedef struct {
      logic [3:0]  opcode;
      logic [30:0] modulus;
      logic [31:0] range_low;
      logic [31:0] range_high;
      bit          drain_first;   // hold this request until every result is back
   } draw_request_type;

   typedef struct {
      logic [63:0] value;
      logic        bad;
   } draw_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_opcode = '0;
   logic [30:0] req_modulus = '0;
   logic [31:0] req_range_low = '0;
   logic [31:0] req_range_high = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_random_value;
   logic        rsp_bad_request;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_start_seed = '0;

   draw_request_type pending_requests[$];
   draw_result_type  expected_draws[$];

   // predictor copy of the seed register and the generator
   logic [63:0] model_seed = '0;
   logic [63:0] model_state = '0;

   int req_issued_cnt = 0;     // requests put on the port (driver side)
   int req_accepted_cnt = 0;   // requests taken by the block (monitor side)
   int req_gap = 0;
   int rsp_stall = 0;
   int idle_pct = 0;           // chance in percent of an idle burst after a transaction
   int error_count = 0;
   int cycle_count = 0;

   mixed_xorshift_random_source u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_modulus      (req_modulus),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value),
      .rsp_bad_request  (rsp_bad_request),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_start_seed   (csr_start_seed)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Generator step: LCG stage (x*5443 + c mod 2^64) followed by the four
   // xorshift stages. The returned word is both the new state and the draw.
   // ---------------------------------------------------------------------------
   function automatic logic [63:0] advance_state(input logic [63:0] s);
      logic [63:0] v;
      v = s * 64'd5443 + 64'd1548586312338621;
      v = v ^ (v >> 19);
      v = v ^ (v << 31);
      v = v ^ (v >> 23);
      v = v ^ (v << 7);
      return v;
   endfunction

   // Works out the one result of an accepted request and queues it.
   // Rejected requests (zero modulus, inverted range) leave the state alone.
   function automatic void predict_draw(input logic [3:0] op, input logic [30:0] modulus,
                                        input logic [31:0] lo, input logic [31:0] hi);
      draw_result_type exp;
      logic [63:0]  drawn;
      logic [63:0]  span;
      logic [63:0]  rem;
      logic [63:0]  shift;
      exp.value = '0;
      exp.bad = 1'b0;
      case (op)
         OP_RAW64, OP_LOW32, OP_LOW16, OP_LOW8, OP_BYTEWIN, OP_BIT: begin
            model_state = advance_state(model_state);
            drawn = model_state;
            case (op)
               OP_RAW64: exp.value = drawn;
               OP_LOW32: exp.value = {32'd0, drawn[31:0]};
               OP_LOW16: exp.value = {48'd0, drawn[15:0]};
               OP_LOW8:  exp.value = {56'd0, drawn[7:0]};
               OP_BIT:   exp.value = {63'd0, drawn[0]};
               default: begin
                  // byte window: shift of 16..47 picked by bits 12..8 of the draw
                  shift = {59'd0, drawn[12:8]} + 64'd16;
                  exp.value = (drawn >> shift) & 64'hFF;
               end
            endcase
         end
         OP_MODULO: begin
            if (modulus == '0) begin
               exp.bad = 1'b1;
            end else begin
               model_state = advance_state(model_state);
               exp.value = model_state % {33'd0, modulus};
            end
         end
         OP_RANGE: begin
            if ($signed(lo) > $signed(hi)) begin
               exp.bad = 1'b1;
            end else begin
               // span is 1 .. 2^32, so it needs more than 32 bits
               span = {{32{hi[31]}}, hi} - {{32{lo[31]}}, lo} + 64'd1;
               model_state = advance_state(model_state);
               rem = model_state % span;
               exp.value = {32'd0, rem[31:0] + lo};
            end
         end
         OP_RELOAD: model_state = model_seed;
         default: ;
      endcase
      expected_draws.push_back(exp);
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: changes the port at the falling edge. A request stays on
   // the port until the monitor has counted its transaction.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_accepted_cnt != req_issued_cnt)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap = req_gap - 1;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain_first && expected_draws.size() != 0)) begin
            req_valid      <= 1'b1;
            req_opcode     <= pending_requests[0].opcode;
            req_modulus    <= pending_requests[0].modulus;
            req_range_low  <= pending_requests[0].range_low;
            req_range_high <= pending_requests[0].range_high;
            void'(pending_requests.pop_front());
            req_issued_cnt = req_issued_cnt + 1;
            if ($urandom_range(0, 99) < idle_pct)
               req_gap = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure in bursts
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < idle_pct)
            rsp_stall = $urandom_range(1, 17);
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: sampled at the rising edge. A request transaction feeds the
   // predictor; a response transaction is checked against the oldest entry.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      draw_result_type exp;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_draw(req_opcode, req_modulus, req_range_low, req_range_high);
            req_accepted_cnt = req_accepted_cnt + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_draws.size() == 0) begin
               $display("%0t: unexpected response: random_value %h bad_request %b",
                        $time, rsp_random_value, rsp_bad_request);
               error_count = error_count + 1;
            end else begin
               exp = expected_draws.pop_front();
               if (rsp_random_value !== exp.value) begin
                  $display("%0t: random_value mismatch: expected %h, actual %h",
                           $time, exp.value, rsp_random_value);
                  error_count = error_count + 1;
               end
               if (rsp_bad_request !== exp.bad) begin
                  $display("%0t: bad_request mismatch: expected %b, actual %b",
                           $time, exp.bad, rsp_bad_request);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void queue_request(input logic [3:0] op, input logic [30:0] modulus,
                                         input logic [31:0] lo, input logic [31:0] hi,
                                         input bit drain_first = 1'b0);
      draw_request_type r;
      r.opcode = op;
      r.modulus = modulus;
      r.range_low = lo;
      r.range_high = hi;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endfunction

   // Mostly well-formed draws with random content; some rejects, reloads and
   // unused opcodes mixed in. Unused opcodes do not count toward n.
   function automatic void queue_random_requests(input int n);
      draw_request_type r;
      int            counted;
      int            pick;
      logic [31:0]   a;
      logic [31:0]   b;
      counted = 0;
      while (counted < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            r.opcode = 4'($urandom_range(OP_RAW64, OP_BIT));
         else if (pick < 65)
            r.opcode = OP_MODULO;
         else if (pick < 87)
            r.opcode = OP_RANGE;
         else if (pick < 95)
            r.opcode = OP_RELOAD;
         else
            r.opcode = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

         r.modulus = 31'($urandom());
         case ($urandom_range(0, 9))
            0: r.modulus = '0;
            1: r.modulus = 31'd1;
            2: r.modulus = '1;
            3, 4, 5: r.modulus = 31'($urandom_range(1, 255));
            default: ;
         endcase

         a = $urandom();
         b = $urandom();
         case ($urandom_range(0, 9))
            0: begin
               // inverted bounds
               r.range_low  = ($signed(a) > $signed(b)) ? a : b;
               r.range_high = ($signed(a) > $signed(b)) ? b : a;
            end
            1: begin
               r.range_low  = 32'h8000_0000;
               r.range_high = 32'h7FFF_FFFF;
            end
            2: begin
               r.range_low  = a;
               r.range_high = a;
            end
            3, 4, 5: begin
               r.range_low  = a;
               r.range_high = a + $urandom_range(0, 100);
               if ($signed(r.range_high) < $signed(r.range_low))
                  r.range_high = 32'h7FFF_FFFF;
            end
            default: begin
               r.range_low  = ($signed(a) <= $signed(b)) ? a : b;
               r.range_high = ($signed(a) <= $signed(b)) ? b : a;
            end
         endcase

         r.drain_first = ($urandom_range(0, 199) == 0);
         pending_requests.push_back(r);
         if (r.opcode <= OP_RELOAD)
            counted = counted + 1;
      end
   endfunction

   // returns at a rising edge once every request is taken and answered
   task automatic settle_until_idle();
      while (pending_requests.size() != 0 || req_accepted_cnt != req_issued_cnt ||
             expected_draws.size() != 0)
         @(posedge clock);
   endtask

   // seed write; the block is idle here, so the predictor is updated directly
   task automatic load_seed(input logic [63:0] seed);
      @(negedge clock);
      csr_start_seed <= seed;
      csr_valid      <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      model_seed  = seed;
      model_state = seed;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, run from the reset state (seed and state both zero).
      idle_pct = 20;
      queue_request(OP_RAW64,   '0, '0, '0);
      queue_request(OP_LOW32,   '1, '1, '1);
      queue_request(OP_LOW16,   '0, '0, '0);
      queue_request(OP_LOW8,    '1, '1, '1);
      queue_request(OP_BYTEWIN, '0, '0, '0);
      queue_request(OP_BIT,     '1, '1, '1);
      queue_request(OP_MODULO,  '0, 32'd5, 32'd9);            // zero modulus: rejected
      queue_request(OP_MODULO,  31'd1, '0, '0);
      queue_request(OP_MODULO,  '1, '1, '1);                  // largest modulus
      queue_request(OP_MODULO,  31'd2, '0, '0);
      queue_request(OP_RANGE,   '0, 32'd1, 32'd0);            // low above high
      queue_request(OP_RANGE,   '0, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_request(OP_RANGE,   '0, 32'd0, 32'hFFFF_FFFF);    // 0 > -1: rejected
      queue_request(OP_RANGE,   '0, 32'h8000_0000, 32'h7FFF_FFFF);  // span of 2^32
      queue_request(OP_RANGE,   '0, 32'h8000_0000, 32'h8000_0000);
      queue_request(OP_RANGE,   '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_request(OP_RANGE,   '0, 32'hFFFF_FFFF, 32'd0);
      queue_request(OP_RELOAD,  '1, '1, '1);
      queue_request(OP_RAW64,   '0, '0, '0, 1'b1);            // after a full drain
      queue_request(OP_UNUSED_LO, '1, '1, '1);
      queue_request(OP_UNUSED_HI, '0, '0, '0);
      queue_request(OP_BYTEWIN, '1, '0, '1);
      queue_request(OP_RAW64,   '0, '1, '0);
      settle_until_idle();

      // seed all ones, moderate idling
      load_seed(64'hFFFF_FFFF_FFFF_FFFF);
      idle_pct = 30;
      queue_random_requests(280);
      settle_until_idle();

      // seed zero, no idling at all
      load_seed(64'd0);
      idle_pct = 0;
      queue_random_requests(280);
      settle_until_idle();

      // random seed, heavy idling on both sides
      load_seed({$urandom(), $urandom()});
      idle_pct = 50;
      queue_random_requests(370);
      settle_until_idle();

      // seed one; the last stretch runs without any idling
      load_seed(64'd1);
      idle_pct = 15;
      queue_random_requests(370);
      while (pending_requests.size() > 150)
         @(posedge clock);
      idle_pct = 0;
      settle_until_idle();

      // let any stray response show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
